/* hdl/ppm_pkg.sv */
`timescale 1ns / 1ps
// Package for the P3 ASCII number parser: request payload types, result
// kinds, magic-line phases and character codes. No dependencies.
package ppm_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_WIDTH     = 3'd0,
    KIND_HEIGHT    = 3'd1,
    KIND_MAXVAL    = 3'd2,
    KIND_SAMPLE    = 3'd3,
    KIND_BAD_MAGIC = 3'd4,
    KIND_BAD_TOKEN = 3'd5
  } kind_t;

  // Progress through the "P3" line
  typedef enum logic [1:0] {
    MAGIC_P    = 2'd0,
    MAGIC_3    = 2'd1,
    MAGIC_LF   = 2'd2,
    MAGIC_DONE = 2'd3
  } magic_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
    logic        overflow;
  } out_item_t;

  // Character codes
  localparam logic [7:0] CHAR_P    = 8'h50;
  localparam logic [7:0] CHAR_3    = 8'h33;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_TAB  = 8'h09;
  localparam logic [7:0] CHAR_VT   = 8'h0B;
  localparam logic [7:0] CHAR_FF   = 8'h0C;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;

  // Number of header values before samples start
  localparam logic [1:0] HEADER_COUNT_MAX = 2'd3;

endpackage

/* hdl/ppm_in_stage.sv */
`timescale 1ns / 1ps
// Input register of the parser: holds one byte request for the parse core.
// Depends on ppm_pkg.
module ppm_in_stage
  import ppm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     s_valid,
  output logic     s_ready,
  input  in_item_t s_item,
  output logic     m_valid,
  input  logic     m_ready,
  output in_item_t m_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // Load whenever empty or the held request moves on this cycle
  assign s_ready   = !valid_r || m_ready;
  assign valid_nxt = s_ready ? s_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item_r <= s_item;
    end
  end

  assign m_valid = valid_r;
  assign m_item  = item_r;

endmodule

/* hdl/ppm_parse_core.sv */
`timescale 1ns / 1ps
// Parse core: stream state and the combinational update for one byte,
// producing at most one result per byte. Depends on ppm_pkg.
module ppm_parse_core
  import ppm_pkg::*;
#(
  parameter int HEADER_VALUE_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  output logic      res_valid,
  output out_item_t res
);

  localparam int W = HEADER_VALUE_WIDTH;

  // State registers
  magic_t         magic_r, magic_nxt;
  logic           line_start_r, line_start_nxt;
  logic           in_comment_r, in_comment_nxt;
  logic           open_r, open_nxt;
  logic           done_r, done_nxt;
  logic           has_digit_r, has_digit_nxt;
  logic [W-1:0]   acc_r, acc_nxt;
  logic [7:0]     low_r, low_nxt;
  logic           sat_r, sat_nxt;
  logic [1:0]     hcount_r, hcount_nxt;
  logic           dropping_r, dropping_nxt;

  // Working signals
  logic [7:0]     c;
  logic [7:0]     want;
  logic           is_digit;
  logic           is_blank;
  logic           sep;
  logic           tok;
  logic           fin;
  logic           base_done;
  logic           base_has;
  logic [W-1:0]   base_acc;
  logic [7:0]     base_low;
  logic           base_sat;
  logic [W+3:0]   acc_sum;
  logic [W+3:0]   acc_max;
  logic [7:0]     low_sum;
  logic [3:0]     digit;
  logic [W+15:0]  acc_ext;

  assign c        = item.byte_in;
  assign digit    = c[3:0];
  assign is_digit = (c >= CHAR_0) && (c <= CHAR_9);
  assign is_blank = (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);

  // Expected byte of the magic line
  always_comb begin
    unique case (magic_r)
      MAGIC_P:  want = CHAR_P;
      MAGIC_3:  want = CHAR_3;
      default:  want = CHAR_LF;
    endcase
  end

  // Token values as seen by this byte: a fresh token starts from zero
  assign base_done = open_r ? done_r      : 1'b0;
  assign base_has  = open_r ? has_digit_r : 1'b0;
  assign base_acc  = open_r ? acc_r       : '0;
  assign base_low  = open_r ? low_r       : 8'd0;
  assign base_sat  = open_r ? sat_r       : 1'b0;

  // Times ten plus digit: the header value saturates at the header limit, the low byte wraps
  assign acc_sum = {1'b0, base_acc, 3'b000} + {3'b000, base_acc, 1'b0}
                 + {{W{1'b0}}, digit};
  assign acc_max = {4'b0000, {W{1'b1}}};
  assign low_sum = {base_low[4:0], 3'b000} + {base_low[6:0], 1'b0} + {4'b0000, digit};

  // Byte update and result
  always_comb begin
    magic_nxt      = magic_r;
    line_start_nxt = line_start_r;
    in_comment_nxt = in_comment_r;
    open_nxt       = open_r;
    done_nxt       = done_r;
    has_digit_nxt  = has_digit_r;
    acc_nxt        = acc_r;
    low_nxt        = low_r;
    sat_nxt        = sat_r;
    hcount_nxt     = hcount_r;
    dropping_nxt   = dropping_r;
    res_valid      = 1'b0;
    res            = '0;
    sep            = 1'b0;
    tok            = 1'b0;
    fin            = 1'b0;
    acc_ext        = '0;

    if (step) begin
      if (dropping_r) begin
        // ignore until end of stream
      end else if (magic_r != MAGIC_DONE) begin
        if (c == want) begin
          magic_nxt = magic_t'(magic_r + 2'd1);
          if (magic_r == MAGIC_LF) begin
            line_start_nxt = 1'b1;
          end
          if (item.last_byte && (magic_r == MAGIC_P)) begin
            res_valid = 1'b1;
            res.kind  = KIND_BAD_MAGIC;
          end
        end else begin
          res_valid    = 1'b1;
          res.kind     = KIND_BAD_MAGIC;
          dropping_nxt = 1'b1;
        end
      end else begin
        // Classify the byte
        if (in_comment_r) begin
          if (c == CHAR_LF) begin
            in_comment_nxt = 1'b0;
            line_start_nxt = 1'b1;
          end
        end else if (c == CHAR_LF) begin
          sep            = 1'b1;
          line_start_nxt = 1'b1;
        end else if (c == CHAR_SP) begin
          sep            = 1'b1;
          line_start_nxt = 1'b0;
        end else if (line_start_r && (c == CHAR_HASH)) begin
          in_comment_nxt = 1'b1;
          line_start_nxt = 1'b0;
        end else begin
          line_start_nxt = 1'b0;
          tok            = 1'b1;
        end

        // Token byte
        if (tok) begin
          open_nxt      = 1'b1;
          done_nxt      = base_done;
          has_digit_nxt = base_has;
          acc_nxt       = base_acc;
          low_nxt       = base_low;
          sat_nxt       = base_sat;
          if (!base_done) begin
            if (!base_has && is_blank) begin
              // leading blank skipped
            end else if (is_digit) begin
              has_digit_nxt = 1'b1;
              low_nxt       = low_sum;
              if (acc_sum > acc_max) begin
                acc_nxt = {W{1'b1}};
                sat_nxt = 1'b1;
              end else begin
                acc_nxt = acc_sum[W-1:0];
              end
            end else begin
              done_nxt = 1'b1;
            end
          end
        end

        // Token end on separator or end of stream
        fin = (sep || item.last_byte) && open_nxt;
        if (fin) begin
          open_nxt  = 1'b0;
          res_valid = 1'b1;
          acc_ext   = {16'd0, acc_nxt};
          if (!has_digit_nxt) begin
            res.kind     = KIND_BAD_TOKEN;
            dropping_nxt = 1'b1;
          end else if (hcount_r != HEADER_COUNT_MAX) begin
            res.kind     = kind_t'({1'b0, hcount_r});
            res.value    = acc_ext[15:0];
            res.overflow = sat_nxt;
            hcount_nxt   = hcount_r + 2'd1;
          end else begin
            res.kind  = KIND_SAMPLE;
            res.value = {8'd0, low_nxt};
          end
        end
      end

      // End of stream: back to the start state
      if (item.last_byte) begin
        magic_nxt      = MAGIC_P;
        line_start_nxt = 1'b1;
        in_comment_nxt = 1'b0;
        open_nxt       = 1'b0;
        done_nxt       = 1'b0;
        has_digit_nxt  = 1'b0;
        acc_nxt        = '0;
        low_nxt        = 8'd0;
        sat_nxt        = 1'b0;
        hcount_nxt     = 2'd0;
        dropping_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r      <= MAGIC_P;
      line_start_r <= 1'b1;
      in_comment_r <= 1'b0;
      open_r       <= 1'b0;
      done_r       <= 1'b0;
      has_digit_r  <= 1'b0;
      acc_r        <= '0;
      low_r        <= 8'd0;
      sat_r        <= 1'b0;
      hcount_r     <= 2'd0;
      dropping_r   <= 1'b0;
    end else begin
      magic_r      <= magic_nxt;
      line_start_r <= line_start_nxt;
      in_comment_r <= in_comment_nxt;
      open_r       <= open_nxt;
      done_r       <= done_nxt;
      has_digit_r  <= has_digit_nxt;
      acc_r        <= acc_nxt;
      low_r        <= low_nxt;
      sat_r        <= sat_nxt;
      hcount_r     <= hcount_nxt;
      dropping_r   <= dropping_nxt;
    end
  end

endmodule

/* hdl/ppm_out_stage.sv */
`timescale 1ns / 1ps
// Result register of the parser: holds one result until the consumer takes
// it. Depends on ppm_pkg.
module ppm_out_stage
  import ppm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_item,
  output logic      can_load,
  output logic      m_valid,
  input  logic      m_ready,
  output out_item_t m_item
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  // Free when empty or being taken this cycle
  assign can_load = !valid_r || m_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (m_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign m_valid = valid_r;
  assign m_item  = item_r;

endmodule

/* hdl/ppm_ascii_number_parser.sv */
`timescale 1ns / 1ps
// P3 ASCII number parser, top level: one byte request per cycle while the result
// register has room. An accepted byte goes into the input register, which feeds
// the parse core; the core loads the result register when that has room.
// Throughput: 1 byte per cycle, held back when the result consumer stalls. Reset:
// synchronous active-low rst_n empties both registers and returns
// the parser to the start of a stream. Depends on ppm_pkg and the ppm_ modules.
module ppm_ascii_number_parser
  import ppm_pkg::*;
#(
  parameter int HEADER_VALUE_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      byte_valid;
  in_item_t  byte_item;
  logic      step;
  logic      can_load;
  logic      res_valid;
  out_item_t res;

  ppm_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_valid),
    .s_ready (in_ready),
    .s_item  (in_item),
    .m_valid (byte_valid),
    .m_ready (can_load),
    .m_item  (byte_item)
  );

  // A byte is processed when the result register has room
  assign step = byte_valid && can_load;

  ppm_parse_core #(
    .HEADER_VALUE_WIDTH (HEADER_VALUE_WIDTH)
  ) u_parse_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (byte_item),
    .res_valid (res_valid),
    .res       (res)
  );

  ppm_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_item (res),
    .can_load  (can_load),
    .m_valid   (out_valid),
    .m_ready   (out_ready),
    .m_item    (out_item)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for the P3 ASCII number parser: byte streams go in, and each result is checked
// against an in-bench parser model. Depends on ppm_pkg and ppm_ascii_number_parser.
module tb_top;
  import ppm_pkg::*;

  localparam int          HDR_WIDTH = 16;
  localparam int unsigned HDR_LIMIT = (1 << HDR_WIDTH) - 1;

  // One pending byte request, with its idling phase and an optional drain hold
  typedef struct {
    in_item_t   item;
    bit         drain_first;
    logic [1:0] phase;
  } byte_req_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  byte_req_t   pending_bytes[$];
  out_item_t   expected_results[$];
  logic [7:0]  stream_buf[$];
  int unsigned bytes_queued = 0;
  int unsigned mismatch_count = 0;
  logic [1:0]  cur_phase = 2'd0;

  // Parser model state
  magic_t      pm_phase;
  bit          at_line_start;
  bit          in_comment_line;
  bit          tok_open;
  bit          tok_past_digits;
  bit          tok_seen_digit;
  int unsigned tok_value;
  logic [7:0]  tok_low8;
  bit          tok_clipped;
  logic [1:0]  hdr_seen;
  bit          skip_to_end;

  ppm_ascii_number_parser #(.HEADER_VALUE_WIDTH(HDR_WIDTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- parser model

  function automatic void restart_stream();
    pm_phase        = MAGIC_P;
    at_line_start   = 1'b1;
    in_comment_line = 1'b0;
    tok_open        = 1'b0;
    tok_past_digits = 1'b0;
    tok_seen_digit  = 1'b0;
    tok_value       = 0;
    tok_low8        = 8'h00;
    tok_clipped     = 1'b0;
    hdr_seen        = 2'd0;
    skip_to_end     = 1'b0;
  endfunction

  // Close the open token, if any; a token without digits poisons the stream
  function automatic bit close_token(output out_item_t res);
    res = '0;
    if (!tok_open) return 1'b0;
    tok_open = 1'b0;
    if (!tok_seen_digit) begin
      res.kind    = KIND_BAD_TOKEN;
      skip_to_end = 1'b1;
    end else if (hdr_seen < HEADER_COUNT_MAX) begin
      res.kind     = kind_t'({1'b0, hdr_seen});
      res.value    = tok_value[15:0];
      res.overflow = tok_clipped;
      hdr_seen++;
    end else begin
      res.kind  = KIND_SAMPLE;
      res.value = {8'h00, tok_low8};
    end
    return 1'b1;
  endfunction

  // Accumulate one token byte: blanks skipped before digits, all bytes ignored after the first other non-digit
  function automatic void token_char(input logic [7:0] c);
    if (!tok_open) begin
      tok_open        = 1'b1;
      tok_past_digits = 1'b0;
      tok_seen_digit  = 1'b0;
      tok_value       = 0;
      tok_low8        = 8'h00;
      tok_clipped     = 1'b0;
    end
    if (tok_past_digits) return;
    if (!tok_seen_digit &&
        (c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF || c == CHAR_CR)) return;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      tok_seen_digit = 1'b1;
      tok_low8       = tok_low8 * 8'd10 + (c - CHAR_0);
      tok_value      = tok_value * 10 + (c - CHAR_0);
      if (tok_value > HDR_LIMIT) begin
        tok_value   = HDR_LIMIT;
        tok_clipped = 1'b1;
      end
    end else begin
      tok_past_digits = 1'b1;
    end
  endfunction

  // Advance the model by one byte; returns 1 when a result is due
  function automatic bit parse_byte(input in_item_t req, output out_item_t res);
    bit         produced;
    logic [7:0] c;
    logic [7:0] want;
    produced = 1'b0;
    c        = req.byte_in;
    res      = '0;
    if (skip_to_end) begin
      // dropping until end of stream
    end else if (pm_phase != MAGIC_DONE) begin
      case (pm_phase)
        MAGIC_P: want = CHAR_P;
        MAGIC_3: want = CHAR_3;
        default: want = CHAR_LF;
      endcase
      if (c == want) begin
        pm_phase = magic_t'(pm_phase + 2'd1);
        if (pm_phase == MAGIC_DONE) at_line_start = 1'b1;
        // stream cut off before the '3'
        if (req.last_byte && pm_phase == MAGIC_3) begin
          res.kind = KIND_BAD_MAGIC;
          produced = 1'b1;
        end
      end else begin
        res.kind    = KIND_BAD_MAGIC;
        skip_to_end = 1'b1;
        produced    = 1'b1;
      end
    end else begin
      if (in_comment_line) begin
        if (c == CHAR_LF) begin
          in_comment_line = 1'b0;
          at_line_start   = 1'b1;
        end
      end else if (c == CHAR_LF) begin
        produced      = close_token(res);
        at_line_start = 1'b1;
      end else if (c == CHAR_SP) begin
        produced      = close_token(res);
        at_line_start = 1'b0;
      end else if (at_line_start && c == CHAR_HASH) begin
        in_comment_line = 1'b1;
        at_line_start   = 1'b0;
      end else begin
        at_line_start = 1'b0;
        token_char(c);
      end
      if (req.last_byte && !produced && !skip_to_end) produced = close_token(res);
    end
    if (req.last_byte) restart_stream();
    return produced;
  endfunction

  // ---------------------------------------------------------------- stream building

  // Append one byte to the stream under construction
  task automatic put_byte(input logic [7:0] b);
    stream_buf.insert(stream_buf.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic add_number(input int unsigned v);
    add_text($sformatf("%0d", v));
  endtask

  task automatic add_digit_run();
    repeat ($urandom_range(10, 14)) put_byte(CHAR_0 + 8'($urandom_range(9)));
  endtask

  // Comment text: any byte but line feed
  task automatic add_comment_body();
    logic [7:0] c;
    repeat ($urandom_range(0, 5)) begin
      c = 8'($urandom_range(255));
      if (c == CHAR_LF) c = CHAR_SP;
      put_byte(c);
    end
  endtask

  task automatic add_value_token(input bit is_header);
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       put_byte(CHAR_TAB);
        1:       put_byte(CHAR_VT);
        2:       put_byte(CHAR_FF);
        default: put_byte(CHAR_CR);
      endcase
    end
    if (is_header) begin
      case ($urandom_range(9))
        0:       add_number($urandom_range(HDR_LIMIT));
        1:       add_number($urandom_range(HDR_LIMIT + 1, 9_999_999));
        2:       add_digit_run();
        default: add_number($urandom_range(1, 40));
      endcase
    end else begin
      case ($urandom_range(7))
        0:       add_number($urandom_range(256, 99_999));
        1:       add_digit_run();
        default: add_number($urandom_range(255));
      endcase
    end
    // trailing junk after the digits
    if ($urandom_range(9) == 0) put_byte(8'($urandom_range(255)));
  endtask

  task automatic add_separator();
    case ($urandom_range(7))
      0: put_byte(CHAR_LF);
      1: add_text("  ");
      2: begin
        add_text("\n#");
        add_comment_body();
        put_byte(CHAR_LF);
      end
      3: add_text(" \n");
      default: put_byte(CHAR_SP);
    endcase
  endtask

  // Well-formed image with random content, sometimes broken
  task automatic build_image_stream();
    add_text("P3\n");
    if ($urandom_range(3) == 0) begin
      put_byte(CHAR_HASH);
      add_comment_body();
      put_byte(CHAR_LF);
    end
    repeat (3) begin
      add_value_token(1'b1);
      add_separator();
    end
    repeat ($urandom_range(1, 12)) begin
      add_value_token(1'b0);
      add_separator();
    end
    // signed or digitless token
    if ($urandom_range(7) == 0) begin
      add_text($urandom_range(1) ? "-" : "+");
      if ($urandom_range(1)) add_value_token(1'b0);
      add_separator();
      add_value_token(1'b0);
      add_separator();
    end
    // let the end of stream close the final token
    if ($urandom_range(1)) void'(stream_buf.pop_back());
    if ($urandom_range(5) == 0)
      stream_buf[$urandom_range(stream_buf.size() - 1)] = 8'($urandom_range(255));
  endtask

  task automatic build_noise_stream();
    case ($urandom_range(3))
      0: add_text("P3\n");
      1: add_text("P");
      2: add_text("P3");
      default: ;
    endcase
    repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(255)));
    if (stream_buf.size() == 0) put_byte(8'($urandom_range(255)));
  endtask

  // Move the built stream to the request queue, marking its final byte
  task automatic queue_stream(input bit drain);
    byte_req_t r;
    foreach (stream_buf[i]) begin
      r.item.byte_in   = stream_buf[i];
      r.item.last_byte = (i == stream_buf.size() - 1);
      r.drain_first    = drain && (i == 0);
      r.phase          = (bytes_queued < 220) ? 2'd0 : (bytes_queued < 440) ? 2'd1 : 2'd2;
      pending_bytes.insert(pending_bytes.size(), r);
      bytes_queued++;
    end
    stream_buf.delete();
  endtask

  function automatic int unsigned send_gap_pct(input logic [1:0] ph);
    return (ph == 2'd0) ? 10 : (ph == 2'd1) ? 58 : 0;
  endfunction

  function automatic int unsigned recv_stall_pct(input logic [1:0] ph);
    return (ph == 2'd0) ? 58 : (ph == 2'd1) ? 10 : 0;
  endfunction

  task automatic report_mismatch(input string what, input out_item_t got,
                                 input out_item_t want);
    mismatch_count++;
    $display("%0t %s: got kind %0d value %0d ovf %0b, want kind %0d value %0d ovf %0b",
             $time, what, got.kind, got.value, got.overflow,
             want.kind, want.value, want.overflow);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : drive_requests
    bit        taken;
    bit        keep;
    out_item_t due;
    byte_req_t next_req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && in_ready;
      if (taken && parse_byte(in_item, due))
        expected_results.insert(expected_results.size(), due);
      keep = in_valid && !taken;
      if (!keep && pending_bytes.size() != 0) begin
        // a drain request waits until every result has been collected
        if (pending_bytes[0].drain_first &&
            (expected_results.size() != 0 || (out_valid && out_ready))) begin
          keep = 1'b0;
        end else if ($urandom_range(99) >= send_gap_pct(pending_bytes[0].phase)) begin
          next_req = pending_bytes.pop_front();
          in_item   <= next_req.item;
          cur_phase <= next_req.phase;
          keep = 1'b1;
        end
      end
      in_valid <= keep;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_item, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.kind !== want.kind || out_item.value !== want.value ||
              out_item.overflow !== want.overflow)
            report_mismatch("result differs", out_item, want);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct(cur_phase));
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    bit first;
    restart_stream();

    // saturated width, skipped tab, junk after digits, comment line, end closes token
    add_text("P3\n#\n70000 ");
    put_byte(CHAR_TAB);
    add_text("9x 3");
    queue_stream(1'b0);
    // carriage return in magic line, then a dropped top-bit byte
    add_text("P");
    put_byte(CHAR_CR);
    put_byte(8'hFF);
    queue_stream(1'b0);
    // stream ends before the '3'
    add_text("P");
    queue_stream(1'b0);
    // sample wrap, CR before digits, hash inside a token, sign token at end
    add_text("P3\n1 1 1 ");
    put_byte(CHAR_CR);
    add_text("300# -");
    queue_stream(1'b0);

    first = 1'b1;
    while (bytes_queued < 650) begin
      if ($urandom_range(7) == 0) build_noise_stream();
      else build_image_stream();
      queue_stream(first || $urandom_range(9) == 0);
      first = 1'b0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
